>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the white balance estimator
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, masked while in reset
`define WBF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// plain invariant checked every clock, masked while in reset
`define WBF_ASSERT_ALW(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

>>> rtl/wbf_pkg.sv
// ----------------------------------------------------------------------------
// wbf_pkg
// shared constants, types and state codes of the white balance estimator
// ----------------------------------------------------------------------------
package wbf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 24;
    localparam int REG_BITS    = 16;
    localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
    localparam int LVL_BITS    = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
    localparam int FACT_BITS   = 24;
    localparam int FRAC_BITS   = 16;
    localparam int DIV_NW      = ((SUM_BITS + 1) > (LVL_BITS + FRAC_BITS + 1)) ?
                                 (SUM_BITS + 1) : (LVL_BITS + FRAC_BITS + 1);
    localparam int DIV_DW      = (COUNT_BITS > LVL_BITS) ? COUNT_BITS : LVL_BITS;
    localparam int DIV_CW      = $clog2(DIV_NW + 1);
    localparam int IN_BITS     = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_RAW     = 1 + 3 * FACT_BITS + 2 + 1 + 2;
    localparam int OUT_BITS    = ((OUT_RAW + 7) / 8) * 8;
    localparam int IDX_BITS    = 3;
    localparam int Q_DEPTH     = 2;
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);

    localparam logic [FACT_BITS-1:0] FACTOR_ONE = FACT_BITS'(1 << FRAC_BITS);
    localparam logic [FACT_BITS-1:0] FACTOR_MAX = '1;

    // configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_LOW_LIMIT  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_HIGH_LIMIT = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_BG_RED     = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_BG_GREEN   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_BG_BLUE    = 3'd4;

    // channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [REG_BITS-1:0] HIGH_LIMIT_RST = 16'd59000;

    typedef logic [SUM_BITS-1:0]   t_sum;
    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [LVL_BITS-1:0]   t_level;

    // one classified pixel handed from front to back
    typedef struct packed {
        logic                  in_range;
        logic                  last;
        t_sum [2:0]            sum;
        logic [COUNT_BITS-1:0] count;
    } t_job;

    // one result beat
    typedef struct packed {
        logic                      in_range;
        logic                      done_res;
        logic [2:0][FACT_BITS-1:0] factor;
        logic [1:0]                ref_ch;
        logic                      status;
        logic [1:0]                failed_ch;
    } t_result;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MSTART,
        B_MWAIT,
        B_EVAL,
        B_FSTART,
        B_FWAIT,
        B_OUT
    } t_bstate;

endpackage

>>> rtl/white_balance_factor_estimator.sv
// ----------------------------------------------------------------------------
// white_balance_factor_estimator
// white-reference white balance factor estimator, top level
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while the queue has room, and each gives one
// result beat carrying its mask bit; intake runs through a two-entry queue, so it
// keeps going while the result side stalls, until the queue is full. The beat of a
// pixel marked last also carries the factors; it comes out after up to five passes
// of a shared radix-2 divider (three means, two factors), each pass a start, the
// quotient steps and a hand-off, plus the control states between taking the last
// pixel off the queue and loading its result beat. Meanwhile intake fills the
// queue and then stalls.
module white_balance_factor_estimator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // red [15:0], green [31:16], blue [47:32]
    input  logic [wbf_pkg::IN_BITS-1:0]    s_axis_tdata,
    input  logic                           s_axis_tlast,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // in_range [0], factor_red [24:1], factor_green [48:25], factor_blue [72:49],
    // reference_channel [74:73], status [75], failed_channel [77:76], zero pad
    output logic [wbf_pkg::OUT_BITS-1:0]   m_axis_tdata,
    // done_res [0]
    output logic                           m_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wbf_pkg::IDX_BITS-1:0]   i_cfg_index,
    input  logic [wbf_pkg::REG_BITS-1:0]   i_cfg_data
);
    import wbf_pkg::*;
`include "assert_macros.svh"

    logic [REG_BITS-1:0]       r_low;
    logic [REG_BITS-1:0]       r_high;
    logic [2:0][REG_BITS-1:0]  r_bg;
    t_sample [2:0]             pix;
    t_job                      push_job;
    t_job                      head_job;
    logic                      push;
    logic                      pop;
    logic                      q_full;
    logic                      q_empty;
    logic [Q_CW-1:0]           q_count;
    t_result                   res;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= HIGH_LIMIT_RST;
            r_bg   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LOW_LIMIT:  r_low   <= i_cfg_data;
                REG_HIGH_LIMIT: r_high  <= i_cfg_data;
                REG_BG_RED:     r_bg[0] <= i_cfg_data;
                REG_BG_GREEN:   r_bg[1] <= i_cfg_data;
                REG_BG_BLUE:    r_bg[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // unpack the pixel beat
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            pix[c] = s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    wbf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_pix    (pix),
        .i_last   (s_axis_tlast),
        .i_low    (r_low),
        .i_high   (r_high),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    wbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    wbf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .i_bg      (r_bg),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    // pack the result beat
    assign m_axis_tdata = OUT_BITS'({res.failed_ch, res.status, res.ref_ch,
                                     res.factor[2], res.factor[1], res.factor[0],
                                     res.in_range});
    assign m_axis_tuser = res.done_res;

    // checks
    `WBF_ASSERT_ALW(a_q_bound, i_clk, i_rst_n, q_count <= Q_CW'(Q_DEPTH), "queue overfilled")
    `WBF_ASSERT_IMP(a_q_pop, i_clk, i_rst_n, pop, !q_empty, "pop from empty queue")
    `WBF_ASSERT_IMP(a_mask_only, i_clk, i_rst_n, m_axis_tvalid && !res.done_res,
        res.factor == '0 && res.status == 1'b0, "factors on a non-final beat")
    `WBF_ASSERT_IMP(a_ref_one, i_clk, i_rst_n, m_axis_tvalid && res.done_res && !res.status,
        res.factor[res.ref_ch] == FACTOR_ONE, "reference factor is not one")

endmodule

>>> rtl/wbf_front.sv
// ----------------------------------------------------------------------------
// wbf_front
// pixel intake: range check, per-channel accumulation, job hand-off
// ----------------------------------------------------------------------------
module wbf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  wbf_pkg::t_sample [2:0]         i_pix,
    input  logic                           i_last,
    input  logic [wbf_pkg::REG_BITS-1:0]   i_low,
    input  logic [wbf_pkg::REG_BITS-1:0]   i_high,
    input  logic                           i_q_full,
    output logic                           o_push,
    output wbf_pkg::t_job                  o_job
);
    import wbf_pkg::*;

    t_sum [2:0]            r_sum;
    logic [COUNT_BITS-1:0] r_count;
    t_sum [2:0]            n_sum;
    logic [COUNT_BITS-1:0] n_count;
    logic                  ok;
    logic                  acc;

    // classify and accumulate
    always_comb begin
        ok = 1'b1;
        for (int c = 0; c < 3; c++) begin
            if (!((t_level'(i_pix[c]) > t_level'(i_low)) &&
                  (t_level'(i_pix[c]) < t_level'(i_high)))) begin
                ok = 1'b0;
            end
        end
        acc = ok && (r_count != '1);
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = acc ? r_sum[c] + SUM_BITS'(i_pix[c]) : r_sum[c];
        end
        n_count = acc ? r_count + 1'b1 : r_count;
    end

    assign o_ready        = !i_q_full;
    assign o_push         = i_valid && !i_q_full;
    assign o_job.in_range = ok;
    assign o_job.last     = i_last;
    assign o_job.sum      = n_sum;
    assign o_job.count    = n_count;

    // running sums, cleared after the last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (o_push) begin
            if (i_last) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
        end
    end

endmodule

>>> rtl/wbf_queue.sv
// ----------------------------------------------------------------------------
// wbf_queue
// two-entry job queue between intake and result stage
// ----------------------------------------------------------------------------
module wbf_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  wbf_pkg::t_job            i_job,
    input  logic                     i_pop,
    output wbf_pkg::t_job            o_job,
    output logic                     o_full,
    output logic                     o_empty,
    output logic [wbf_pkg::Q_CW-1:0] o_count
);
    import wbf_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic            r_wp;
    logic            r_rp;
    logic [Q_CW-1:0] r_cnt;

    assign o_job   = r_mem[r_rp];
    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + Q_CW'(i_push) - Q_CW'(i_pop);
        end
    end

endmodule

>>> rtl/wbf_div.sv
// ----------------------------------------------------------------------------
// wbf_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wbf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wbf_pkg::t_div_req          i_req,
    output logic                       o_done,
    output logic [wbf_pkg::DIV_NW-1:0] o_quot
);
    import wbf_pkg::*;

    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   sh;
    logic [DIV_DW:0]   diff;
    logic              ge;

    // one trial subtraction
    always_comb begin
        sh   = {r_rem, r_quo[DIV_NW-1]};
        diff = sh - {1'b0, r_den};
        ge   = (sh >= {1'b0, r_den});
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    // payload shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NW-2:0], ge};
            r_rem <= ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/wbf_back.sv
// ----------------------------------------------------------------------------
// wbf_back
// result stage: mask beats, means, reference choice and factors
// ----------------------------------------------------------------------------
module wbf_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  wbf_pkg::t_job                       i_job,
    output logic                                o_pop,
    input  logic [2:0][wbf_pkg::REG_BITS-1:0]   i_bg,
    output logic                                o_valid,
    input  logic                                i_ready,
    output wbf_pkg::t_result                    o_res
);
    import wbf_pkg::*;

    t_bstate               r_state, n_state;
    t_job                  r_job;
    logic [1:0]            r_ch;
    t_sample [2:0]         r_mean;
    t_level [2:0]          r_level;
    logic [1:0]            r_rc;
    logic                  r_fail;
    logic [1:0]            r_fail_ch;
    logic [2:0][FACT_BITS-1:0] r_fact;
    t_result               r_out;
    logic                  r_ovalid;

    t_div_req              req;
    logic                  div_done;
    logic [DIV_NW-1:0]     quot;
    logic                  out_free;
    t_level [2:0]          lvl;
    logic [1:0]            rc;
    logic                  load_mask;
    logic                  load_final;
    logic [FACT_BITS-1:0]  sat;

    wbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign out_free = !r_ovalid || i_ready;
    assign o_valid  = r_ovalid;
    assign o_res    = r_out;
    assign sat      = (quot > DIV_NW'(FACTOR_MAX)) ? FACTOR_MAX : quot[FACT_BITS-1:0];

    // levels and reference channel from the registered means
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            lvl[c] = (t_level'(r_mean[c]) >= t_level'(i_bg[c])) ?
                     t_level'(r_mean[c]) - t_level'(i_bg[c]) :
                     t_level'(i_bg[c]) - t_level'(r_mean[c]);
        end
        if (lvl[0] > lvl[1]) rc = (lvl[0] > lvl[2]) ? CH_RED : CH_BLUE;
        else                 rc = (lvl[1] > lvl[2]) ? CH_GREEN : CH_BLUE;
    end

    // sequencer next state and divider requests
    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        load_mask  = 1'b0;
        load_final = 1'b0;
        req.start  = 1'b0;
        req.num    = DIV_NW'(r_job.sum[r_ch]) + DIV_NW'(r_job.count >> 1);
        req.den    = DIV_DW'(r_job.count);
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    if (!i_job.last) begin
                        if (out_free) begin
                            o_pop     = 1'b1;
                            load_mask = 1'b1;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_state = (i_job.count == '0) ? B_EVAL : B_MSTART;
                    end
                end
            end
            B_MSTART: begin
                req.start = 1'b1;
                n_state   = B_MWAIT;
            end
            B_MWAIT: begin
                if (div_done) n_state = (r_ch == CH_BLUE) ? B_EVAL : B_MSTART;
            end
            B_EVAL: begin
                n_state = (r_mean[0] == '0 || r_mean[1] == '0 || r_mean[2] == '0) ?
                          B_OUT : B_FSTART;
            end
            B_FSTART: begin
                req.num = DIV_NW'({r_level[r_rc], FRAC_BITS'(0)}) +
                          DIV_NW'(r_level[r_ch] >> 1);
                req.den = DIV_DW'(r_level[r_ch]);
                if (r_ch == r_rc || r_level[r_ch] == '0) begin
                    if (r_ch == CH_BLUE) n_state = B_OUT;
                end else begin
                    req.start = 1'b1;
                    n_state   = B_FWAIT;
                end
            end
            B_FWAIT: begin
                if (div_done) n_state = (r_ch == CH_BLUE) ? B_OUT : B_FSTART;
            end
            B_OUT: begin
                if (out_free) begin
                    load_final = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else          r_state <= n_state;
    end

    // working registers of the final computation
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job  <= i_job;
                r_ch   <= CH_RED;
                r_mean <= '0;
                r_fact <= '0;
            end
            B_MWAIT: begin
                if (div_done) begin
                    r_mean[r_ch] <= quot[SAMPLE_BITS-1:0];
                    r_ch         <= r_ch + 1'b1;
                end
            end
            B_EVAL: begin
                r_level   <= lvl;
                r_rc      <= rc;
                r_ch      <= CH_RED;
                r_fail    <= (r_mean[0] == '0 || r_mean[1] == '0 || r_mean[2] == '0);
                r_fail_ch <= (r_mean[0] == '0) ? CH_RED :
                             (r_mean[1] == '0) ? CH_GREEN : CH_BLUE;
            end
            B_FSTART: begin
                if (r_ch == r_rc) begin
                    r_fact[r_ch] <= FACTOR_ONE;
                    r_ch         <= r_ch + 1'b1;
                end else if (r_level[r_ch] == '0) begin
                    r_fact[r_ch] <= FACTOR_MAX;
                    r_ch         <= r_ch + 1'b1;
                end
            end
            B_FWAIT: begin
                if (div_done) begin
                    r_fact[r_ch] <= sat;
                    r_ch         <= r_ch + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load_mask) begin
            r_out <= {i_job.in_range, {($bits(t_result) - 1){1'b0}}};
        end else if (load_final) begin
            r_out.in_range  <= r_job.in_range;
            r_out.done_res  <= 1'b1;
            r_out.factor    <= r_fail ? '0 : r_fact;
            r_out.ref_ch    <= r_fail ? CH_RED : r_rc;
            r_out.status    <= r_fail;
            r_out.failed_ch <= r_fail ? r_fail_ch : CH_RED;
        end
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                      r_ovalid <= 1'b0;
        else if (load_mask || load_final)  r_ovalid <= 1'b1;
        else if (i_ready)                  r_ovalid <= 1'b0;
    end

endmodule
